FILE: rtl/assert_macros.svh
// Assertion macros shared by the projector RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define APR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define APR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/apr_pkg.sv
// Package for the attitude point projector: widths, register indexes, types.
// No dependencies.
package apr_pkg;

	localparam int COORD_BITS     = 12;
	localparam int OUT_BITS       = 16;
	localparam int TRIG_FRAC_BITS = 14;

	localparam int TRIG_W = 16;
	localparam int DIST_W = 12;
	localparam int IDX_W  = 3;
	localparam int CFG_W  = 16;

	localparam logic [IDX_W-1:0] REG_ROLL_COS  = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROLL_SIN  = 3'd1;
	localparam logic [IDX_W-1:0] REG_PITCH_COS = 3'd2;
	localparam logic [IDX_W-1:0] REG_PITCH_SIN = 3'd3;
	localparam logic [IDX_W-1:0] REG_EYE_DIST  = 3'd4;

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// rotated numerators, scale 2^(2F)
	localparam int RX_W  = imax(imax(COORD_BITS + TRIG_W + TRIG_FRAC_BITS, COORD_BITS + 2 * TRIG_W),
		DIST_W + 1 + 2 * TRIG_W) + 2;
	localparam int MAG_W = RX_W + DIST_W;
	// depth, scale 2^F
	localparam int Z_W   = imax(COORD_BITS + TRIG_W, DIST_W + 1 + TRIG_W) + 1;
	localparam int DEN_W = Z_W + TRIG_FRAC_BITS + 1;
	localparam int NUM_W = imax(MAG_W + 1, Z_W + TRIG_FRAC_BITS) + 1;
	localparam int REM_W = imax(NUM_W, DEN_W + OUT_BITS) + 1;

	localparam int IN_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((2 * OUT_BITS + 7) / 8) * 8;

	localparam logic signed [Z_W-1:0] Z_HALF = Z_W'(1) <<< (TRIG_FRAC_BITS - 1);

	typedef struct packed {
		logic signed [TRIG_W-1:0] cr;
		logic signed [TRIG_W-1:0] sr;
		logic signed [TRIG_W-1:0] cp;
		logic signed [TRIG_W-1:0] sp;
		logic [DIST_W-1:0]        d;
	} apr_cfg_t;

	localparam apr_cfg_t CFG_RST = '{
		cr: TRIG_W'(1 << TRIG_FRAC_BITS),
		sr: '0,
		cp: TRIG_W'(1 << TRIG_FRAC_BITS),
		sp: '0,
		d:  DIST_W'(300)
	};

	// fraction pair handed from the front end to the dividers
	typedef struct packed {
		logic [NUM_W-1:0] num_x;
		logic [NUM_W-1:0] num_y;
		logic [DEN_W-1:0] den;
		logic             neg_x;
		logic             neg_y;
		logic             clamped;
	} apr_frac_t;

	// saturate a rounded quotient magnitude into a signed result
	function automatic logic [OUT_BITS-1:0] apr_sat(input logic [OUT_BITS-1:0] q,
		input logic ovf, input logic neg);
		logic [OUT_BITS-1:0] lim;
		lim = OUT_BITS'(1) << (OUT_BITS - 1);
		if (neg) begin
			return (ovf || q > lim) ? lim : OUT_BITS'(-q);
		end
		return (ovf || q > lim - OUT_BITS'(1)) ? lim - OUT_BITS'(1) : q;
	endfunction

endpackage

FILE: rtl/apr_front.sv
// Front end: rotation products, depth clamp, numerator and denominator forming.
// Five register stages; depends on apr_pkg.
`include "assert_macros.svh"
module apr_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  apr_pkg::apr_cfg_t                      cfg,
	input  logic                                   in_valid,
	input  logic signed [apr_pkg::COORD_BITS-1:0]  x,
	input  logic signed [apr_pkg::COORD_BITS-1:0]  y,
	output logic                                   out_valid,
	output apr_pkg::apr_frac_t                     frac
);
	import apr_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int F  = TRIG_FRAC_BITS;

	logic [5:1] v_q;

	// stage 1: first-level products
	logic signed [C+TRIG_W-1:0]   xc_s1, xs_s1, ysp_s1;
	logic signed [2*TRIG_W-1:0]   scp_s1, ccp_s1, ssp_s1, csp_s1;
	logic signed [DIST_W+TRIG_W:0] dcp_s1;
	logic signed [C-1:0]          y_s1;
	logic [DIST_W-1:0]            d_s1;

	// stage 2: products with y and d, depth sum
	logic signed [C+TRIG_W-1:0]        xc_s2, xs_s2;
	logic signed [C+2*TRIG_W-1:0]      ty1_s2, ty2_s2;
	logic signed [DIST_W+2*TRIG_W:0]   td1_s2, td2_s2;
	logic signed [Z_W-1:0]             z_s2;
	logic [DIST_W-1:0]                 d_s2;

	// stage 3: rotated numerators and clamped depth
	logic signed [RX_W-1:0] rx_s3, ry_s3;
	logic [Z_W-1:0]         zmag_s3;
	logic                   zneg_s3, clamp_s3;
	logic [DIST_W-1:0]      d_s3;

	// stage 4: magnitudes times d
	logic [MAG_W-1:0] magx_s4, magy_s4;
	logic [Z_W-1:0]   zmag_s4;
	logic             negx_s4, negy_s4, clamp_s4;

	logic signed [RX_W-1:0] rx_c, ry_c;
	logic                   small_c;
	logic [RX_W-1:0]        arx_c, ary_c;

	always_comb begin
		rx_c = (RX_W'(xc_s2) <<< F) - RX_W'(ty1_s2) + RX_W'(td1_s2);
		ry_c = (RX_W'(xs_s2) <<< F) + RX_W'(ty2_s2) - RX_W'(td2_s2);
		small_c = (z_s2 > -Z_HALF) && (z_s2 < Z_HALF);
		arx_c = rx_s3[RX_W-1] ? unsigned'(-rx_s3) : unsigned'(rx_s3);
		ary_c = ry_s3[RX_W-1] ? unsigned'(-ry_s3) : unsigned'(ry_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[4:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xc_s1  <= x * cfg.cr;
			xs_s1  <= x * cfg.sr;
			ysp_s1 <= y * cfg.sp;
			scp_s1 <= cfg.sr * cfg.cp;
			ccp_s1 <= cfg.cr * cfg.cp;
			ssp_s1 <= cfg.sr * cfg.sp;
			csp_s1 <= cfg.cr * cfg.sp;
			dcp_s1 <= $signed({1'b0, cfg.d}) * cfg.cp;
			y_s1   <= y;
			d_s1   <= cfg.d;

			xc_s2  <= xc_s1;
			xs_s2  <= xs_s1;
			ty1_s2 <= y_s1 * scp_s1;
			ty2_s2 <= y_s1 * ccp_s1;
			td1_s2 <= $signed({1'b0, d_s1}) * ssp_s1;
			td2_s2 <= $signed({1'b0, d_s1}) * csp_s1;
			z_s2   <= Z_W'(ysp_s1) + Z_W'(dcp_s1);
			d_s2   <= d_s1;

			rx_s3    <= rx_c;
			ry_s3    <= ry_c;
			zneg_s3  <= z_s2[Z_W-1];
			clamp_s3 <= small_c;
			zmag_s3  <= small_c ? unsigned'(Z_HALF)
				: (z_s2[Z_W-1] ? unsigned'(-z_s2) : unsigned'(z_s2));
			d_s3     <= d_s2;

			magx_s4  <= MAG_W'(arx_c) * MAG_W'(d_s3);
			magy_s4  <= MAG_W'(ary_c) * MAG_W'(d_s3);
			negx_s4  <= rx_s3[RX_W-1] ^ zneg_s3;
			negy_s4  <= ry_s3[RX_W-1] ^ zneg_s3;
			zmag_s4  <= zmag_s3;
			clamp_s4 <= clamp_s3;

			// round to nearest: (2*mag + den) / (2*den), den = |z|*2^F
			frac.num_x   <= (NUM_W'(magx_s4) << 1) + (NUM_W'(zmag_s4) << F);
			frac.num_y   <= (NUM_W'(magy_s4) << 1) + (NUM_W'(zmag_s4) << F);
			frac.den     <= DEN_W'(zmag_s4) << (F + 1);
			frac.neg_x   <= negx_s4;
			frac.neg_y   <= negy_s4;
			frac.clamped <= clamp_s4;
		end
	end

	assign out_valid = v_q[5];

	`APR_ASSERT(a_clamp_half, v_q[3] && clamp_s3 |-> zmag_s3 == unsigned'(Z_HALF),
		"clamped depth is not one half")
	`APR_ASSERT(a_depth_floor, v_q[3] |-> zmag_s3 >= unsigned'(Z_HALF),
		"depth magnitude below one half")

endmodule

FILE: rtl/apr_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on apr_pkg.
`include "assert_macros.svh"
module apr_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [apr_pkg::NUM_W-1:0]     num,
	input  logic [apr_pkg::DEN_W-1:0]     den,
	input  logic                          neg,
	input  logic                          tag,
	output logic                          out_valid,
	output logic [apr_pkg::OUT_BITS-1:0]  quo,
	output logic                          ovf,
	output logic                          neg_o,
	output logic                          tag_o
);
	import apr_pkg::*;

	localparam int N = OUT_BITS;

	logic                v_s   [0:N];
	logic [REM_W-1:0]    rem_s [0:N];
	logic [DEN_W-1:0]    dsr_s [0:N];
	logic [N-1:0]        quo_s [0:N];
	logic                ovf_s [0:N];
	logic                neg_s [0:N];
	logic                tag_s [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= REM_W'(num);
			dsr_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= REM_W'(num) >= (REM_W'(den) << N);
			neg_s[0] <= neg;
			tag_s[0] <= tag;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		localparam int B = N - 1 - i;
		logic [REM_W-1:0] shd;
		logic             ge;
		assign shd = REM_W'(dsr_s[i]) << B;
		assign ge  = rem_s[i] >= shd;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? rem_s[i] - shd : rem_s[i];
				quo_s[i+1] <= {quo_s[i][N-2:0], ge};
				dsr_s[i+1] <= dsr_s[i];
				ovf_s[i+1] <= ovf_s[i];
				neg_s[i+1] <= neg_s[i];
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign out_valid = v_s[N];
	assign quo       = quo_s[N];
	assign ovf       = ovf_s[N];
	assign neg_o     = neg_s[N];
	assign tag_o     = tag_s[N];

	`APR_ASSERT(a_rem_below, v_s[N] && !ovf_s[N] |-> rem_s[N] < REM_W'(dsr_s[N]),
		"final remainder not below divisor")

endmodule

FILE: rtl/attitude_point_projector.sv
// Top level of the attitude point projector: config registers, pipeline, output.
// Depends on apr_pkg, apr_front and apr_div.
//
// Use:
//  - Write roll/pitch cosines and sines (Q2.14) and the eye distance through
//    cfg_we / cfg_index / cfg_data while the block is idle.
//  - Input items arrive on s_tvalid / s_tready / s_tdata: one screen point.
//  - Each item gives exactly one result on m_tvalid / m_tready / m_tdata
//    with the depth-clamp flag in m_tuser.
//  - Throughput: one item per clock unless the receiver stalls. The valid path from
//    acceptance to m_tvalid runs through 23 registers, the first loaded at acceptance:
//    5 front-end stages (multipliers, depth clamp), 1 + 16 divider stages
//    (one quotient bit each) and the output register.
//  - The pipeline advances as a whole; when the receiver holds m_tready low
//    with a result pending, every stage holds and s_tready drops, so no
//    item is lost or repeated.
//  - Reset clears all valid bits and loads the registers with roll and
//    pitch of zero and an eye distance of 300 pixels.
`include "assert_macros.svh"
module attitude_point_projector (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [apr_pkg::IDX_W-1:0]           cfg_index,
	input  logic [apr_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// point_x, point_y
	input  logic [apr_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// screen_x, screen_y
	output logic [apr_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// depth_clamped
	output logic                                m_tuser
);
	import apr_pkg::*;

	apr_cfg_t  cfg_q;
	apr_frac_t frac;
	logic      adv;
	logic      fv;

	logic                dvx, dvy;
	logic [OUT_BITS-1:0] qx, qy;
	logic                ovfx, ovfy, negx, negy, clampx, clampy;

	logic [OUT_BITS-1:0] sx_q, sy_q;
	logic                clamp_q;

	// whole pipe moves unless a result is stuck at the output
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROLL_COS:  cfg_q.cr <= signed'(cfg_data[TRIG_W-1:0]);
				REG_ROLL_SIN:  cfg_q.sr <= signed'(cfg_data[TRIG_W-1:0]);
				REG_PITCH_COS: cfg_q.cp <= signed'(cfg_data[TRIG_W-1:0]);
				REG_PITCH_SIN: cfg_q.sp <= signed'(cfg_data[TRIG_W-1:0]);
				REG_EYE_DIST:  cfg_q.d  <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	apr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.x         (signed'(s_tdata[COORD_BITS-1:0])),
		.y         (signed'(s_tdata[2*COORD_BITS-1:COORD_BITS])),
		.out_valid (fv),
		.frac      (frac)
	);

	// x divider carries the clamp flag; y divider copy is the same
	apr_div u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (fv),
		.num       (frac.num_x),
		.den       (frac.den),
		.neg       (frac.neg_x),
		.tag       (frac.clamped),
		.out_valid (dvx),
		.quo       (qx),
		.ovf       (ovfx),
		.neg_o     (negx),
		.tag_o     (clampx)
	);

	apr_div u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (fv),
		.num       (frac.num_y),
		.den       (frac.den),
		.neg       (frac.neg_y),
		.tag       (frac.clamped),
		.out_valid (dvy),
		.quo       (qy),
		.ovf       (ovfy),
		.neg_o     (negy),
		.tag_o     (clampy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= dvx;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_q    <= apr_sat(qx, ovfx, negx);
			sy_q    <= apr_sat(qy, ovfy, negy);
			clamp_q <= clampx;
		end
	end

	always_comb begin
		m_tdata = '0;
		m_tdata[OUT_BITS-1:0]          = sx_q;
		m_tdata[2*OUT_BITS-1:OUT_BITS] = sy_q;
		m_tuser = clamp_q;
	end

	`APR_ASSERT(a_stall_blocks, m_tvalid && !m_tready |-> !s_tready,
		"input taken while output is stalled")
	`APR_ASSERT(a_div_lockstep, dvx == dvy && (!dvx || clampx == clampy),
		"x and y dividers out of step")
	`APR_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !m_tvalid,
		"output valid during reset")

endmodule

FILE: tb/tb_attitude_point_projector.sv
// Testbench for attitude_point_projector: streams screen points, checks projections.
// Depends on apr_pkg and the projector RTL; self-checking, no files read.
`timescale 1ns / 1ps
module tb_attitude_point_projector;
	import apr_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct packed {
		logic [OUT_BITS-1:0] sx;
		logic [OUT_BITS-1:0] sy;
		logic                clamped;
	} proj_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic m_tuser;

	// predictor copy of the registers
	logic signed [15:0] cr_q = 16'sd16384, sr_q = 16'sd0, cp_q = 16'sd16384, sp_q = 16'sd0;
	logic [11:0] d_q = 12'd300;

	proj_t expected_proj[$];
	int errors = 0;
	int points_sent = 0;
	int results_seen = 0;
	int clamps_seen = 0;
	int idle_cycles = 0;
	bit hold_sink = 1'b0;
	bit random_sink = 1'b1;

	always #1 clk = ~clk;

	attitude_point_projector dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// round(num*d/den) with ties away from zero, saturated to OUT_BITS
	function automatic logic [OUT_BITS-1:0] scale_round(longint num, longint d,
		longint den, bit neg_den);
		bit neg;
		longint mag, q, lim;
		neg = (num < 0) != neg_den;
		mag = (num < 0 ? -num : num) * d;
		q = (2 * mag + den) / (2 * den);
		lim = longint'(1) << (OUT_BITS - 1);
		if (mag == 0) return '0;
		if (neg) return OUT_BITS'(-(q > lim ? lim : q));
		return OUT_BITS'(q > lim - 1 ? lim - 1 : q);
	endfunction

	function automatic proj_t project_point(logic [COORD_BITS-1:0] px,
		logic [COORD_BITS-1:0] py);
		longint x, y, d, one, half, rx, ry, z, den;
		proj_t r;
		x = longint'($signed(px));
		y = longint'($signed(py));
		d = longint'(d_q);
		one = longint'(1) << TRIG_FRAC_BITS;
		half = one / 2;
		rx = x * cr_q * one - y * (sr_q * cp_q) + d * (sr_q * sp_q);
		ry = x * sr_q * one + y * (cr_q * cp_q) - d * (cr_q * sp_q);
		z = y * sp_q + d * cp_q;
		r.clamped = 1'b0;
		if (z > -half && z < half) begin
			z = (z < 0) ? -half : half;
			r.clamped = 1'b1;
		end
		den = (z < 0 ? -z : z) * one;
		r.sx = scale_round(rx, d, den, z < 0);
		r.sy = scale_round(ry, d, den, z < 0);
		return r;
	endfunction

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ROLL_COS:  cr_q = val;
			REG_ROLL_SIN:  sr_q = val;
			REG_PITCH_COS: cp_q = val;
			REG_PITCH_SIN: sp_q = val;
			REG_EYE_DIST:  d_q = val[11:0];
			default: ;
		endcase
	endtask

	task automatic set_attitude(int cr, int sr, int cp, int sp, int d);
		write_reg(REG_ROLL_COS, CFG_W'(cr));
		write_reg(REG_ROLL_SIN, CFG_W'(sr));
		write_reg(REG_PITCH_COS, CFG_W'(cp));
		write_reg(REG_PITCH_SIN, CFG_W'(sp));
		write_reg(REG_EYE_DIST, CFG_W'(d));
	endtask

	// sender: random gap, then hold the item until accepted
	task automatic send_point(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
		bit gaps = 1'b1);
		int gap;
		gap = gaps ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_TDATA_W'({py, px});
		expected_proj.push_back(project_point(px, py));
		do @(posedge clk); while (!s_tready);
		points_sent++;
	endtask

	task automatic end_burst();
		s_tvalid <= 1'b0;
	endtask

	// wait for the pipeline to empty, then let it settle before config writes
	task automatic drain();
		end_burst();
		while (expected_proj.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [COORD_BITS-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 12'h800;
			1: return 12'h7FF;
			2: return 12'(int'($urandom_range(0, 8)) - 4);
			default: return 12'($urandom);
		endcase
	endfunction

	function automatic int rand_trig();
		case ($urandom_range(0, 4))
			0: return 16384;
			1: return -16384;
			2: return 0;
			default: return int'($urandom_range(0, 32768)) - 16384;
		endcase
	endfunction

	// receiver: random stalls, always ready when random_sink is clear, or held off entirely during the pressure test
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_sink) begin
			m_tready <= 1'b0;
		end else if (!random_sink) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 11) == 0) || ($urandom_range(0, 2) == 0);
		end
	end

	// result checker
	always @(posedge clk) begin
		proj_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.sx = m_tdata[OUT_BITS-1:0];
			got.sy = m_tdata[2*OUT_BITS-1:OUT_BITS];
			got.clamped = m_tuser;
			results_seen++;
			if (got.clamped) clamps_seen++;
			if (expected_proj.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = expected_proj.pop_front();
				if (got.sx !== want.sx) begin
					$display("%0t: screen_x expected %0d actual %0d", $time,
						$signed(want.sx), $signed(got.sx));
					errors++;
				end
				if (got.sy !== want.sy) begin
					$display("%0t: screen_y expected %0d actual %0d", $time,
						$signed(want.sy), $signed(got.sy));
					errors++;
				end
				if (got.clamped !== want.clamped) begin
					$display("%0t: depth_clamped expected %0b actual %0b", $time,
						want.clamped, got.clamped);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles with no handshake on either side while the sink is not held
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_sink)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("tb_attitude_point_projector NOT OK");
			$finish;
		end
	end

	// level flight at reset values, field extremes and zero point
	task automatic test_reset_attitude();
		send_point(12'h000, 12'h000);
		send_point(12'h7FF, 12'h7FF);
		send_point(12'h800, 12'h800);
		send_point(12'h7FF, 12'h800);
		send_point(12'h800, 12'h7FF);
		send_point(12'hFFF, 12'h001);
		drain();
	endtask

	// register extremes: depth clamp, zero depth, negative depth, saturation
	task automatic test_register_extremes();
		set_attitude(16384, 0, 0, 0, 300);      // zero depth: clamp to +0.5
		send_point(12'h005, 12'h7FF);
		send_point(12'h800, 12'h800);
		drain();
		set_attitude(-16384, 16384, 0, 16384, 4095); // depth from y only
		send_point(12'h000, 12'h000);
		send_point(12'h7FF, 12'hFFF);             // small negative depth
		send_point(12'h800, 12'h001);
		send_point(12'h7FF, 12'h7FF);
		drain();
		set_attitude(16384, -16384, -16384, -16384, 1); // negative depth
		send_point(12'h7FF, 12'h800);
		send_point(12'h003, 12'h000);
		drain();
		set_attitude(16384, 16384, 16384, 16384, 0); // zero eye distance
		send_point(12'h7FF, 12'h7FF);
		send_point(12'h800, 12'h123);
		drain();
		write_reg(3'd7, 16'hFFFF);               // unused index, ignored
		set_attitude(32767, -32768, 1, -1, 4095); // extreme raw Q2.14 values, beyond any unit sine or cosine
		send_point(12'h7FF, 12'h800);
		send_point(12'h001, 12'h7FF);
		drain();
	endtask

	// receiver held off while the sender keeps offering
	task automatic test_backpressure();
		int n;
		set_attitude(15137, 6270, 14189, -8192, 300);
		hold_sink = 1'b1;
		fork
			begin
				repeat (200) @(posedge clk);
				hold_sink = 1'b0;
			end
			for (n = 0; n < 60; n++) send_point(rand_coord(), rand_coord(), 1'b0);
		join
		drain();
	endtask

	// random attitudes, each with a burst of random points
	task automatic test_random_points();
		int phase, n, burst;
		for (phase = 0; phase < 16; phase++) begin
			set_attitude(rand_trig(), rand_trig(), rand_trig(), rand_trig(),
				$urandom_range(0, 3) == 0 ? $urandom_range(1, 4095) :
				$urandom_range(1, 600));
			random_sink = (phase % 4 != 3);
			burst = 50;
			for (n = 0; n < burst; n++) send_point(rand_coord(), rand_coord(), phase % 4 != 3);
			drain();
		end
		random_sink = 1'b1;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_attitude();
		test_register_extremes();
		test_backpressure();
		test_random_points();
		$display("Sent %0d points over several attitudes, %0d results, %0d with depth clamp.",
			points_sent, results_seen, clamps_seen);
		if (errors == 0) begin
			$display("tb_attitude_point_projector OK");
		end else begin
			$display("tb_attitude_point_projector NOT OK");
		end
		$finish;
	end

endmodule
